// ----- hdl/nearest_descriptor_match_unit_defines.svh -----
// Assertion macros used by the descriptor matcher's checker.
`ifndef NEAREST_DESCRIPTOR_MATCH_UNIT_DEFINES_SVH
`define NEAREST_DESCRIPTOR_MATCH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define NDM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is high.
`define NDM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ----- hdl/ndm_pkg.sv -----
// Package: widths, codes and shared types of the descriptor matcher.
`timescale 1ns / 1ps
package ndm_pkg;

   localparam int PATCH_SIDE_DEF = 9;
   localparam int MAX_REFS_DEF   = 64;

   localparam int TYPE_W = 2;
   localparam int IDX_W  = 7;
   localparam int ELEM_W = 16;
   localparam int ID_W   = 16;
   localparam int DIST_W = 39;
   localparam int SQ_W   = 32;
   localparam int SUM_W  = DIST_W + 1;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // Request codes
   localparam logic [TYPE_W-1:0] REQ_LOAD  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } acc_ctrl_type;

   typedef struct packed {
      logic              done;
      logic [DIST_W-1:0] total;
   } acc_out_type;

endpackage

// ----- hdl/ndm_if.sv -----
// Interfaces: request, response and register write channels.
`timescale 1ns / 1ps
interface ndm_req_if;
   logic                              valid;
   logic                              ready;
   logic [ndm_pkg::TYPE_W-1:0]        req_type;
   logic [ndm_pkg::IDX_W-1:0]         elem_index;
   logic signed [ndm_pkg::ELEM_W-1:0] elem_value;
   logic [ndm_pkg::ID_W-1:0]          feature_id;
   logic                              last_element;

   modport source (output valid, req_type, elem_index, elem_value, feature_id, last_element,
                   input ready);
   modport sink (input valid, req_type, elem_index, elem_value, feature_id, last_element,
                 output ready);
endinterface

interface ndm_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ndm_pkg::ID_W-1:0]   query_id;
   logic [ndm_pkg::ID_W-1:0]   best_ref_id;
   logic [ndm_pkg::DIST_W-1:0] best_distance;
   logic                       match_found;

   modport source (output valid, query_id, best_ref_id, best_distance, match_found,
                   input ready);
   modport sink (input valid, query_id, best_ref_id, best_distance, match_found,
                 output ready);
endinterface

interface ndm_csr_if;
   logic                       valid;
   logic                       ready;
   logic [ndm_pkg::DIST_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ----- hdl/ndm_sq_acc.sv -----
// Squared-difference and saturating accumulate pipeline.
`timescale 1ns / 1ps
module ndm_sq_acc (
   input  logic                             clock,
   input  logic                             reset,
   input  ndm_pkg::acc_ctrl_type            ctrl,
   input  logic [ndm_pkg::ELEM_W-1:0]       q_elem,
   input  logic [ndm_pkg::ELEM_W-1:0]       r_elem,
   output ndm_pkg::acc_out_type             acc_out
);

   logic signed [ndm_pkg::ELEM_W:0]       diff;
   logic signed [2*ndm_pkg::ELEM_W+1:0]   prod;
   logic [ndm_pkg::SQ_W-1:0]              sq_ff, sq_in;
   ndm_pkg::acc_ctrl_type                 sq_ctrl_ff;
   logic [ndm_pkg::SUM_W-1:0]             sum_wide;
   logic [ndm_pkg::DIST_W-1:0]            sum_ff, sum_in;
   logic                                  done_ff, done_in;

   // Stage one: square the element difference
   always_comb begin
      diff  = $signed({q_elem[ndm_pkg::ELEM_W-1], q_elem})
            - $signed({r_elem[ndm_pkg::ELEM_W-1], r_elem});
      prod  = diff * diff;
      sq_in = prod[ndm_pkg::SQ_W-1:0];
   end

   // Stage two: accumulate with saturation, restart on a slot's first element
   always_comb begin
      sum_wide = (sq_ctrl_ff.first ? {ndm_pkg::SUM_W{1'b0}} : {1'b0, sum_ff})
               + ndm_pkg::SUM_W'(sq_ff);
      sum_in   = sum_ff;
      if (sq_ctrl_ff.valid) begin
         if (sum_wide > {1'b0, ndm_pkg::DIST_MAX}) begin
            sum_in = ndm_pkg::DIST_MAX;
         end else begin
            sum_in = sum_wide[ndm_pkg::DIST_W-1:0];
         end
      end
      done_in = sq_ctrl_ff.valid && sq_ctrl_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ctrl_ff <= '0;
         done_ff    <= 1'b0;
      end else begin
         sq_ctrl_ff <= ctrl;
         done_ff    <= done_in;
      end
      sq_ff  <= sq_in;
      sum_ff <= sum_in;
   end

   always_comb begin
      acc_out.done  = done_ff;
      acc_out.total = sum_ff;
   end

endmodule

// ----- hdl/nearest_descriptor_match_unit.sv -----
// A query's last element starts a walk over the stored references (scan, drain, id
// read, done), or goes straight to done with an empty reference set; the walk reads
// one element per cycle from the reference memory, which sets the rate. No new
// transaction is taken during the walk. Reset clears the reference count and control
// state and sets the match limit to its maximum; the descriptor memories are not
// cleared and there is no clearing pass.
`timescale 1ns / 1ps
module nearest_descriptor_match_unit #(
   parameter int PATCH_SIDE = ndm_pkg::PATCH_SIDE_DEF,
   parameter int MAX_REFS   = ndm_pkg::MAX_REFS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ndm_req_if.sink    req_in,
   ndm_rsp_if.source  rsp_out,
   ndm_csr_if.sink    csr_wr
);

   localparam int DESC_LEN    = PATCH_SIDE * PATCH_SIDE;
   localparam int STORE_DEPTH = MAX_REFS * DESC_LEN;
   localparam int K_W         = (DESC_LEN > 1) ? $clog2(DESC_LEN) : 1;
   localparam int A_W         = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int SLOT_W      = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
   localparam int CNT_W       = $clog2(MAX_REFS + 1);
   localparam logic [K_W-1:0] K_LAST = K_W'(DESC_LEN - 1);

   // One-hot sequencer states
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_ID    = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [A_W:0]                load_base_ff, load_base_in;
   logic [ndm_pkg::DIST_W-1:0]  limit_ff, limit_in;

   logic [K_W-1:0]              k_ff, k_in;
   logic [SLOT_W-1:0]           slot_ff, slot_in;
   logic [A_W-1:0]              scan_base_ff, scan_base_in;
   ndm_pkg::acc_ctrl_type       rd_ctrl_ff, rd_ctrl_in;

   logic [SLOT_W-1:0]           done_slot_ff, done_slot_in;
   logic [SLOT_W-1:0]           best_slot_ff, best_slot_in;
   logic [ndm_pkg::DIST_W-1:0]  best_ff, best_in;
   logic                        have_ff, have_in;
   logic [ndm_pkg::ID_W-1:0]    qid_ff, qid_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ndm_pkg::ID_W-1:0]    rsp_qid_ff, rsp_qid_in;
   logic [ndm_pkg::ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [ndm_pkg::DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;
   logic                        rsp_found_ff, rsp_found_in;

   // Memories and their registered read data
   logic [ndm_pkg::ELEM_W-1:0]  ref_mem [STORE_DEPTH];
   logic [ndm_pkg::ID_W-1:0]    id_mem  [MAX_REFS];
   logic [ndm_pkg::ELEM_W-1:0]  q_mem   [DESC_LEN];
   logic [ndm_pkg::ELEM_W-1:0]  r_rd_ff, q_rd_ff;
   logic [ndm_pkg::ID_W-1:0]    id_rd_ff;

   logic                        req_fire;
   logic                        idx_ok;
   logic                        room;
   logic                        ld_we;
   logic                        q_we;
   logic [A_W-1:0]              ref_waddr;
   logic [A_W-1:0]              ref_raddr;
   logic                        found;
   ndm_pkg::acc_out_type        acc_out;

   // Take transactions only between walks; register writes are always welcome
   assign req_in.ready = (state_ff == ST_IDLE);
   assign csr_wr.ready = 1'b1;
   assign req_fire     = req_in.valid && req_in.ready;

   // Drop element writes past the descriptor end; the last mark still acts
   assign idx_ok    = 8'(req_in.elem_index) < 8'(DESC_LEN);
   assign room      = count_ff < CNT_W'(MAX_REFS);
   assign ld_we     = req_fire && (req_in.req_type == ndm_pkg::REQ_LOAD) && room;
   assign q_we      = req_fire && (req_in.req_type == ndm_pkg::REQ_QUERY) && idx_ok;
   assign ref_waddr = load_base_ff[A_W-1:0] + A_W'(req_in.elem_index);
   assign ref_raddr = scan_base_ff + A_W'(k_ff);

   always_ff @(posedge clock) begin
      if (ld_we && idx_ok) begin
         ref_mem[ref_waddr] <= req_in.elem_value;
      end
      if (ld_we) begin
         id_mem[count_ff[SLOT_W-1:0]] <= req_in.feature_id;
      end
      if (q_we) begin
         q_mem[K_W'(req_in.elem_index)] <= req_in.elem_value;
      end
      r_rd_ff  <= ref_mem[ref_raddr];
      q_rd_ff  <= q_mem[k_ff];
      id_rd_ff <= id_mem[best_slot_ff];
   end

   // Square-and-accumulate pipeline; reports one total per reference slot
   ndm_sq_acc u_acc (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (rd_ctrl_ff),
      .q_elem  (q_rd_ff),
      .r_elem  (r_rd_ff),
      .acc_out (acc_out)
   );

   assign found = have_ff && (best_ff < limit_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      load_base_in = load_base_ff;
      limit_in     = limit_ff;
      k_in         = k_ff;
      slot_in      = slot_ff;
      scan_base_in = scan_base_ff;
      done_slot_in = done_slot_ff;
      best_slot_in = best_slot_ff;
      best_in      = best_ff;
      have_in      = have_ff;
      qid_in       = qid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_qid_in   = rsp_qid_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_found_in = rsp_found_ff;

      // Memory read data arrives in the cycle after its address
      rd_ctrl_in.valid = (state_ff == ST_SCAN);
      rd_ctrl_in.first = (k_ff == '0);
      rd_ctrl_in.last  = (k_ff == K_LAST);

      if (csr_wr.valid && csr_wr.ready) begin
         limit_in = csr_wr.data;
      end

      // Retire the response transaction
      if (rsp_out.valid && rsp_out.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Keep the first strict minimum over the slot totals
      if (acc_out.done) begin
         done_slot_in = done_slot_ff + SLOT_W'(1);
         if (!have_ff || (acc_out.total < best_ff)) begin
            have_in      = 1'b1;
            best_in      = acc_out.total;
            best_slot_in = done_slot_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_in.req_type)
                  ndm_pkg::REQ_LOAD: begin
                     // Commit the slot on its last element; ignore loads once full
                     if (room && req_in.last_element) begin
                        count_in     = count_ff + CNT_W'(1);
                        load_base_in = load_base_ff + (A_W+1)'(DESC_LEN);
                     end
                  end
                  ndm_pkg::REQ_CLEAR: begin
                     count_in     = '0;
                     load_base_in = '0;
                  end
                  ndm_pkg::REQ_QUERY: begin
                     if (req_in.last_element) begin
                        qid_in       = req_in.feature_id;
                        k_in         = '0;
                        slot_in      = '0;
                        scan_base_in = '0;
                        done_slot_in = '0;
                        have_in      = 1'b0;
                        best_in      = ndm_pkg::DIST_MAX;
                        if (count_ff == '0) begin
                           state_in = ST_DONE;
                        end else begin
                           state_in = ST_SCAN;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Advance through each element of each stored reference
            if (k_ff == K_LAST) begin
               k_in = '0;
               if ((CNT_W'(slot_ff) + CNT_W'(1)) == count_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  slot_in      = slot_ff + SLOT_W'(1);
                  scan_base_in = scan_base_ff + A_W'(DESC_LEN);
               end
            end else begin
               k_in = k_ff + K_W'(1);
            end
         end
         ST_DRAIN: begin
            // Wait for the final slot total to pass the compare
            if (acc_out.done && ((CNT_W'(done_slot_ff) + CNT_W'(1)) == count_ff)) begin
               state_in = ST_ID;
            end
         end
         ST_ID: begin
            // Best slot's id is read this cycle
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_out.ready) begin
               rsp_valid_in = 1'b1;
               rsp_qid_in   = qid_ff;
               rsp_id_in    = found ? id_rd_ff : '0;
               rsp_dist_in  = best_ff;
               rsp_found_in = found;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         load_base_ff <= '0;
         limit_ff     <= ndm_pkg::DIST_MAX;
         rd_ctrl_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         load_base_ff <= load_base_in;
         limit_ff     <= limit_in;
         rd_ctrl_ff   <= rd_ctrl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff         <= k_in;
      slot_ff      <= slot_in;
      scan_base_ff <= scan_base_in;
      done_slot_ff <= done_slot_in;
      best_slot_ff <= best_slot_in;
      best_ff      <= best_in;
      have_ff      <= have_in;
      qid_ff       <= qid_in;
      rsp_qid_ff   <= rsp_qid_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_found_ff <= rsp_found_in;
   end

   // Drive the response channel from the output register
   assign rsp_out.valid         = rsp_valid_ff;
   assign rsp_out.query_id      = rsp_qid_ff;
   assign rsp_out.best_ref_id   = rsp_id_ff;
   assign rsp_out.best_distance = rsp_dist_ff;
   assign rsp_out.match_found   = rsp_found_ff;

endmodule

// ----- hdl/ndm_checker.sv -----
// Port-level checker for the descriptor matcher, bound to the top level.
`timescale 1ns / 1ps
`include "nearest_descriptor_match_unit_defines.svh"
module ndm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [ndm_pkg::TYPE_W-1:0]  req_type,
   input logic                        last_element,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [ndm_pkg::ID_W-1:0]    best_ref_id,
   input logic [ndm_pkg::DIST_W-1:0]  best_distance,
   input logic                        match_found,
   input logic                        csr_valid,
   input logic                        csr_ready,
   input logic [ndm_pkg::DIST_W-1:0]  csr_data
);

   logic [1:0]                 pending_ff, pending_in;
   logic [ndm_pkg::DIST_W-1:0] limit_ff, limit_in;
   logic                       q_done;
   logic                       r_done;

   assign q_done = req_valid && req_ready && (req_type == ndm_pkg::REQ_QUERY) && last_element;
   assign r_done = rsp_valid && rsp_ready;

   // Track answers owed and the limit last written
   always_comb begin
      pending_in = pending_ff + {1'b0, q_done} - {1'b0, r_done};
      limit_in   = (csr_valid && csr_ready) ? csr_data : limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         limit_ff   <= ndm_pkg::DIST_MAX;
      end else begin
         pending_ff <= pending_in;
         limit_ff   <= limit_in;
      end
   end

   `NDM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `NDM_ASSERT_IMPLY(a_rsp_owed, clock, reset, rsp_valid, pending_ff != 2'd0)
   `NDM_ASSERT_IMPLY(a_match_below_limit, clock, reset, rsp_valid && match_found, best_distance < limit_ff)
   `NDM_ASSERT_IMPLY(a_no_match_zero_id, clock, reset, rsp_valid && !match_found, best_ref_id == '0)

endmodule

bind nearest_descriptor_match_unit ndm_checker u_ndm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_in.valid),
   .req_ready     (req_in.ready),
   .req_type      (req_in.req_type),
   .last_element  (req_in.last_element),
   .rsp_valid     (rsp_out.valid),
   .rsp_ready     (rsp_out.ready),
   .best_ref_id   (rsp_out.best_ref_id),
   .best_distance (rsp_out.best_distance),
   .match_found   (rsp_out.match_found),
   .csr_valid     (csr_wr.valid),
   .csr_ready     (csr_wr.ready),
   .csr_data      (csr_wr.data)
);
